// ----- rtl/core/rsss_pkg.sv -----
`timescale 1ns / 1ps

package rsss_pkg;

  // scan size and range precision
  localparam int MAX_BEAMS  = 1024;
  localparam int RANGE_BITS = 16;

  // derived widths
  localparam int IDX_W   = $clog2(MAX_BEAMS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int POS_W   = CNT_W + 1;
  localparam int SQ_W    = 2 * RANGE_BITS;
  localparam int SHIFT_W = 11;
  localparam int SUM_W   = 42;
  localparam int FIELD_W = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // one input beat: one beam of the scan
  typedef struct packed {
    logic [FIELD_W-1:0] measured_range;
    logic [FIELD_W-1:0] modelled_range;
    logic               in_measured_set;
    logic               in_model_set;
    logic               last_beam;
  } beam_t;

  // one output beat: the search result
  typedef struct packed {
    logic signed [SHIFT_W-1:0] best_shift;
    logic [SUM_W-1:0]          best_error_sum;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic init_search;
    logic issue;
    logic compare;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic few_models;
    logic last_index;
    logic last_shift;
    logic pipe_busy;
    logic out_full;
  } dp_sts_t;

  // controller states
  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_START  = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_STEP   = 5'b10000
  } ctrl_state_t;

endpackage

// ----- rtl/core/range_shift_ssd_search.sv -----
`timescale 1ns / 1ps

// Range shift search by least sum of squared differences. Beams are taken one
// a cycle while loading into two 1024-entry stores, each with one write and one
// read port; beams past the store depth are dropped, but a dropped beam marked
// last still starts the search. With N stored beams and M model-set beams, the
// search tries every shift from -(M-1) to M-2, walking the stored beams once
// per shift at one beam per cycle through a four-stage read, difference, square
// and accumulate pipeline; with M below two the result is shift 0, sum 0. The
// result sits in an output register, so the next scan starts loading as soon
// as it is placed. No clearing pass is needed after reset.
module range_shift_ssd_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              beam_valid,
  output logic              beam_ready,
  input  rsss_pkg::beam_t   beam,
  output logic              result_valid,
  input  logic              result_ready,
  output rsss_pkg::result_t result
);

  rsss_pkg::ctrl_cmd_t cmd;
  rsss_pkg::dp_sts_t   sts;

  // sequencing
  rsss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .beam_valid   (beam_valid),
    .last_beam    (beam.last_beam),
    .beam_ready   (beam_ready),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // stores, pipeline and result register
  rsss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .beam         (beam),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ----- rtl/core/rsss_datapath.sv -----
`timescale 1ns / 1ps

module rsss_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rsss_pkg::beam_t     beam,
  input  rsss_pkg::ctrl_cmd_t cmd,
  output rsss_pkg::dp_sts_t   sts,
  output rsss_pkg::result_t   result,
  output logic                result_valid,
  input  logic                result_ready
);

  localparam int RB    = rsss_pkg::RANGE_BITS;
  localparam int IDX_W = rsss_pkg::IDX_W;
  localparam int CNT_W = rsss_pkg::CNT_W;
  localparam int POS_W = rsss_pkg::POS_W;
  localparam int SQ_W  = rsss_pkg::SQ_W;
  localparam int SUM_W = rsss_pkg::SUM_W;
  localparam int SH_W  = rsss_pkg::SHIFT_W;

  // beam stores: measured range with its set flag, and modelled range
  logic [RB:0]   meas_mem [rsss_pkg::MAX_BEAMS];
  logic [RB-1:0] model_mem [rsss_pkg::MAX_BEAMS];

  logic [CNT_W-1:0]        beam_count;
  logic [CNT_W-1:0]        model_count;
  logic [CNT_W-1:0]        idx;
  logic signed [SH_W-1:0]  shift_d;
  logic                    first_shift;
  logic [SUM_W-1:0]        acc;
  logic [SUM_W-1:0]        least_sum;
  logic signed [SH_W-1:0]  least_shift;

  logic                    store_en;
  logic signed [POS_W-1:0] pos;
  logic                    pos_in;
  logic signed [POS_W-1:0] first_pos;
  logic signed [POS_W-1:0] stop_pos;

  // pipeline registers
  logic [RB:0]     meas_rd;
  logic [RB-1:0]   model_rd;
  logic            v1, in1, v2, v3;
  logic [RB-1:0]   diff;
  logic [SQ_W-1:0] sq;
  logic [RB-1:0]   model_eff;
  logic [RB-1:0]   meas_val;
  logic [SUM_W:0]  acc_sum;

  assign store_en  = cmd.store && (beam_count < CNT_W'(rsss_pkg::MAX_BEAMS));
  assign pos       = $signed({1'b0, idx}) + POS_W'(shift_d);
  assign pos_in    = !pos[POS_W-1] && (pos[CNT_W-1:0] < beam_count);
  assign first_pos = POS_W'(1) - $signed(POS_W'(model_count));
  assign stop_pos  = $signed(POS_W'(model_count)) - POS_W'(2);

  // status to the controller
  assign sts.few_models = model_count < CNT_W'(2);
  assign sts.last_index = (idx + CNT_W'(1)) == beam_count;
  assign sts.last_shift = POS_W'(shift_d) == stop_pos;
  assign sts.pipe_busy  = v1 | v2 | v3;
  assign sts.out_full   = result_valid;

  // measured store, one write and one read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      meas_mem[beam_count[IDX_W-1:0]] <=
        {beam.in_measured_set, beam.measured_range[RB-1:0]};
    end
    if (cmd.issue) begin
      meas_rd <= meas_mem[idx[IDX_W-1:0]];
    end
  end

  // model store, read at the shifted position
  always_ff @(posedge clk) begin
    if (store_en) begin
      model_mem[beam_count[IDX_W-1:0]] <= beam.modelled_range[RB-1:0];
    end
    if (cmd.issue) begin
      model_rd <= model_mem[pos[IDX_W-1:0]];
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      beam_count  <= '0;
      model_count <= '0;
    end else if (store_en) begin
      beam_count  <= beam_count + CNT_W'(1);
      model_count <= model_count + CNT_W'(beam.in_model_set);
    end
  end

  // shift and beam index sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      shift_d     <= '0;
      first_shift <= 1'b0;
    end else if (cmd.init_search) begin
      idx         <= '0;
      shift_d     <= first_pos[SH_W-1:0];
      first_shift <= 1'b1;
    end else if (cmd.issue) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.compare) begin
      idx         <= '0;
      shift_d     <= shift_d + SH_W'(1);
      first_shift <= 1'b0;
    end
  end

  // difference stage
  assign model_eff = in1 ? model_rd : '0;
  assign meas_val  = meas_rd[RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1 && meas_rd[RB];
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    in1  <= pos_in;
    diff <= (model_eff > meas_val) ? (model_eff - meas_val) : (meas_val - model_eff);
    sq   <= SQ_W'(diff) * SQ_W'(diff);
  end

  // saturating accumulate
  assign acc_sum = {1'b0, acc} + (SUM_W + 1)'(sq);

  always_ff @(posedge clk) begin
    if (rst || cmd.init_search || cmd.compare || cmd.emit) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc_sum[SUM_W] ? rsss_pkg::SUM_MAX : acc_sum[SUM_W-1:0];
    end
  end

  // best shift so far
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      least_sum   <= rsss_pkg::SUM_MAX;
      least_shift <= '0;
    end else if (cmd.compare && (first_shift || acc < least_sum)) begin
      least_sum   <= acc;
      least_shift <= shift_d;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.best_shift     <= sts.few_models ? '0 : least_shift;
      result.best_error_sum <= sts.few_models ? '0 : least_sum;
    end
  end

  // checks
  a_compare_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |-> !(v1 || v2 || v3))
    else $error("shift compared before pipeline drained");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> idx < beam_count)
    else $error("beam read beyond stored scan");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> beam_count == '0 && model_count == '0 && result_valid)
    else $error("scan state not cleared after result");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !result_valid || result_ready)
    else $error("result overwritten before taken");

endmodule

// ----- rtl/core/rsss_ctrl.sv -----
`timescale 1ns / 1ps

module rsss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                beam_valid,
  input  logic                last_beam,
  output logic                beam_ready,
  input  logic                result_ready,
  input  rsss_pkg::dp_sts_t   sts,
  output rsss_pkg::ctrl_cmd_t cmd
);

  rsss_pkg::ctrl_state_t state, state_next;
  logic finish, finish_next;
  logic can_emit;

  assign can_emit = !sts.out_full || result_ready;

  // next state and commands
  always_comb begin
    state_next  = state;
    finish_next = finish;
    cmd         = '0;
    beam_ready  = 1'b0;
    unique case (state)
      rsss_pkg::S_LOAD: begin
        if (finish) begin
          if (can_emit) begin
            cmd.emit    = 1'b1;
            finish_next = 1'b0;
          end
        end else begin
          beam_ready = 1'b1;
          if (beam_valid) begin
            cmd.store = 1'b1;
            if (last_beam) begin
              state_next = rsss_pkg::S_START;
            end
          end
        end
      end
      rsss_pkg::S_START: begin
        if (sts.few_models) begin
          finish_next = 1'b1;
          state_next  = rsss_pkg::S_LOAD;
        end else begin
          cmd.init_search = 1'b1;
          state_next      = rsss_pkg::S_SWEEP;
        end
      end
      rsss_pkg::S_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.last_index) begin
          state_next = rsss_pkg::S_DRAIN;
        end
      end
      rsss_pkg::S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = rsss_pkg::S_STEP;
        end
      end
      rsss_pkg::S_STEP: begin
        cmd.compare = 1'b1;
        if (sts.last_shift) begin
          finish_next = 1'b1;
          state_next  = rsss_pkg::S_LOAD;
        end else begin
          state_next = rsss_pkg::S_SWEEP;
        end
      end
      default: begin
        state_next  = rsss_pkg::S_LOAD;
        finish_next = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rsss_pkg::S_LOAD;
      finish <= 1'b0;
    end else begin
      state  <= state_next;
      finish <= finish_next;
    end
  end

  // checks
  a_no_load_while_finishing: assert property (@(posedge clk) disable iff (rst)
    finish |-> !beam_ready)
    else $error("beam taken before previous search result placed");

  a_issue_only_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> state == rsss_pkg::S_SWEEP && !beam_ready)
    else $error("beam read outside sweep");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.store && last_beam |=> state == rsss_pkg::S_START)
    else $error("last beam did not start search");

endmodule
